[rtl/core/ctlt_pkg.sv]
// Shared types, token and mode codes, and character classification helpers
// for the C-like byte stream tokenizer. No dependencies.
package ctlt_pkg;

  typedef enum logic [4:0] {
    M_IDLE = 5'd0, M_DOT = 5'd1, M_HASH = 5'd2, M_LBRK = 5'd3, M_RBRK = 5'd4,
    M_BANG = 5'd5, M_EQ = 5'd6, M_GT = 5'd7, M_GTGT = 5'd8, M_LT = 5'd9,
    M_LTLT = 5'd10, M_PLUS = 5'd11, M_MINUS = 5'd12, M_STAR = 5'd13,
    M_SLASH = 5'd14, M_PCT = 5'd15, M_AMP = 5'd16, M_BAR = 5'd17,
    M_CARET = 5'd18, M_LINECMT = 5'd19, M_BLOCK = 5'd20, M_BLOCKSTAR = 5'd21,
    M_STRING = 5'd22, M_IDENT = 5'd23, M_ZERO = 5'd24, M_INTDIG = 5'd25,
    M_FRAC = 5'd26, M_EXP = 5'd27, M_EXPDIG = 5'd28
  } mode_t;

  localparam logic [5:0] K_END = 6'd0, K_NL = 6'd1, K_LPAREN = 6'd2,
    K_RPAREN = 6'd3, K_LBRACE = 6'd4, K_RBRACE = 6'd5, K_SEMI = 6'd6,
    K_COMMA = 6'd7, K_TILDE = 6'd8, K_QUEST = 6'd9, K_COLON = 6'd10,
    K_HASHHASH = 6'd11, K_HASH = 6'd12, K_ELLIPSIS = 6'd13, K_DOT = 6'd14,
    K_LLBRK = 6'd15, K_LBRK = 6'd16, K_RRBRK = 6'd17, K_RBRK = 6'd18,
    K_NE = 6'd19, K_NOT = 6'd20, K_EQEQ = 6'd21, K_ASSIGN = 6'd22,
    K_SHRASSIGN = 6'd23, K_SHR = 6'd24, K_GE = 6'd25, K_GT = 6'd26,
    K_SHLASSIGN = 6'd27, K_SHL = 6'd28, K_LE = 6'd29, K_LT = 6'd30,
    K_INC = 6'd31, K_ADDASSIGN = 6'd32, K_ADD = 6'd33, K_DEC = 6'd34,
    K_SUBASSIGN = 6'd35, K_SUB = 6'd36, K_MULASSIGN = 6'd37, K_MUL = 6'd38,
    K_DIVASSIGN = 6'd39, K_DIV = 6'd40, K_MODASSIGN = 6'd41, K_MOD = 6'd42,
    K_LAND = 6'd43, K_ANDASSIGN = 6'd44, K_AND = 6'd45, K_LOR = 6'd46,
    K_ORASSIGN = 6'd47, K_OR = 6'd48, K_XORASSIGN = 6'd49, K_XOR = 6'd50,
    K_INT = 6'd51, K_FLOAT = 6'd52, K_STRING = 6'd53, K_IDENT = 6'd54,
    K_ERROR = 6'd55;

  localparam logic [1:0] E_NONE = 2'd0, E_BLOCK = 2'd1, E_STRING = 2'd2,
    E_BYTE = 2'd3;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [23:0] ID_AND = 24'h616E64, ID_NOT = 24'h6E6F74;
  localparam logic [23:0] ID_OR = 24'h006F72;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [1:0]  error_code;
    logic [31:0] start_offset;
    logic [19:0] start_row;
    logic [15:0] start_column;
    logic [15:0] token_length;
    logic [63:0] int_value;
    logic        last_of_run;
  } tok_t;

  function automatic logic is_dec(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_dec(c) || c == "_";
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

  function automatic logic is_digit(logic [7:0] c, logic hex);
    return is_dec(c) || (hex && ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")));
  endfunction

  function automatic logic [3:0] digit_val(logic [7:0] c);
    logic [3:0] d;
    if (is_dec(c)) begin
      d = c[3:0];
    end else begin
      d = c[3:0] + 4'd9;
    end
    return d;
  endfunction

  function automatic logic is_exp(logic [7:0] c, logic hex);
    return hex ? (c == "p" || c == "P") : (c == "e" || c == "E");
  endfunction

  function automatic logic [5:0] idle_kind(logic [7:0] c);
    logic [5:0] k;
    case (c)
      CH_NL: k = K_NL;
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      ";": k = K_SEMI;
      ",": k = K_COMMA;
      "~": k = K_TILDE;
      "?": k = K_QUEST;
      ":": k = K_COLON;
      default: k = K_END;
    endcase
    return k;
  endfunction

  function automatic mode_t idle_mode(logic [7:0] c);
    mode_t m;
    case (c)
      "#": m = M_HASH;
      ".": m = M_DOT;
      "[": m = M_LBRK;
      "]": m = M_RBRK;
      "!": m = M_BANG;
      "=": m = M_EQ;
      ">": m = M_GT;
      "<": m = M_LT;
      "+": m = M_PLUS;
      "-": m = M_MINUS;
      "*": m = M_STAR;
      "/": m = M_SLASH;
      "%": m = M_PCT;
      "&": m = M_AMP;
      "|": m = M_BAR;
      "^": m = M_CARET;
      "\"": m = M_STRING;
      default: m = M_IDLE;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] op_ext(mode_t m, logic [7:0] c);
    logic [5:0] k;
    k = K_END;
    case (m)
      M_HASH: if (c == "#") k = K_HASHHASH;
      M_LBRK: if (c == "[") k = K_LLBRK;
      M_RBRK: if (c == "]") k = K_RRBRK;
      M_BANG: if (c == "=") k = K_NE;
      M_EQ: if (c == "=") k = K_EQEQ;
      M_GT: if (c == "=") k = K_GE;
      M_GTGT: if (c == "=") k = K_SHRASSIGN;
      M_LT: if (c == "=") k = K_LE;
      M_LTLT: if (c == "=") k = K_SHLASSIGN;
      M_PLUS: if (c == "+") k = K_INC; else if (c == "=") k = K_ADDASSIGN;
      M_MINUS: if (c == "-") k = K_DEC; else if (c == "=") k = K_SUBASSIGN;
      M_STAR: if (c == "=") k = K_MULASSIGN;
      M_SLASH: if (c == "=") k = K_DIVASSIGN;
      M_PCT: if (c == "=") k = K_MODASSIGN;
      M_AMP: if (c == "&") k = K_LAND; else if (c == "=") k = K_ANDASSIGN;
      M_BAR: if (c == "|") k = K_LOR; else if (c == "=") k = K_ORASSIGN;
      M_CARET: if (c == "=") k = K_XORASSIGN;
      default: k = K_END;
    endcase
    return k;
  endfunction

  function automatic mode_t op_chain(mode_t m, logic [7:0] c);
    mode_t r;
    r = M_IDLE;
    case (m)
      M_GT: if (c == ">") r = M_GTGT;
      M_LT: if (c == "<") r = M_LTLT;
      M_SLASH: if (c == "/") r = M_LINECMT; else if (c == "*") r = M_BLOCK;
      default: r = M_IDLE;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] op_default(mode_t m);
    logic [5:0] k;
    case (m)
      M_HASH: k = K_HASH;
      M_LBRK: k = K_LBRK;
      M_RBRK: k = K_RBRK;
      M_BANG: k = K_NOT;
      M_EQ: k = K_ASSIGN;
      M_GT: k = K_GT;
      M_GTGT: k = K_SHR;
      M_LT: k = K_LT;
      M_LTLT: k = K_SHL;
      M_PLUS: k = K_ADD;
      M_MINUS: k = K_SUB;
      M_STAR: k = K_MUL;
      M_SLASH: k = K_DIV;
      M_PCT: k = K_MOD;
      M_AMP: k = K_AND;
      M_BAR: k = K_OR;
      M_CARET: k = K_XOR;
      default: k = K_END;
    endcase
    return k;
  endfunction

endpackage

[rtl/core/ctlt_ifs.sv]
// Valid/ready channel interfaces for the tokenizer input bytes and output tokens.
// Depends on nothing.
interface ctlt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;
  modport source(output valid, char_byte, end_of_text, input ready);
  modport sink(input valid, char_byte, end_of_text, output ready);
endinterface

interface ctlt_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [1:0]  error_code;
  logic [31:0] start_offset;
  logic [19:0] start_row;
  logic [15:0] start_column;
  logic [15:0] token_length;
  logic [63:0] int_value;
  logic        last_of_run;
  modport source(output valid, token_kind, error_code, start_offset, start_row,
                 start_column, token_length, int_value, last_of_run, input ready);
  modport sink(input valid, token_kind, error_code, start_offset, start_row,
               start_column, token_length, int_value, last_of_run, output ready);
endinterface

[rtl/core/c_like_byte_stream_tokenizer_top.sv]
// Tokens of a byte are written into the four-entry token queue and offered from there.
// Throughput: one byte per cycle while input is ready; extra tokens drain one per cycle
// while the output is ready, and input waits while the queue holds two or more.
// Reset (synchronous, active high) returns the scanner to idle at offset 0, row 1,
// column 1 and empties the queue.
module c_like_byte_stream_tokenizer_top #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  ctlt_in_if.sink    in_ch,
  ctlt_out_if.source out_ch
);

  ctlt_pkg::tok_t [2:0] toks;
  logic [1:0] tok_cnt;
  logic room;
  logic take;

  assign in_ch.ready = room;
  assign take = in_ch.valid && room;

  ctlt_step #(
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .clk(clk),
    .rst(rst),
    .take(take),
    .char_byte(in_ch.char_byte),
    .end_of_text(in_ch.end_of_text),
    .toks(toks),
    .tok_cnt(tok_cnt)
  );

  ctlt_tokq u_tokq (
    .clk(clk),
    .rst(rst),
    .push(take),
    .toks(toks),
    .tok_cnt(tok_cnt),
    .room(room),
    .out_ch(out_ch)
  );

endmodule

[rtl/core/ctlt_step.sv]
// Scanner state register and the combinational next-state logic that turns one
// byte into zero to three tokens. Depends on ctlt_pkg.
module ctlt_step #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic [7:0]               char_byte,
  input  logic                     end_of_text,
  output ctlt_pkg::tok_t [2:0]     toks,
  output logic [1:0]               tok_cnt
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [19:0] ROW_MAX = '1;
  localparam logic [15:0] COL_MAX = '1;

  typedef struct packed {
    ctlt_pkg::mode_t        m;
    logic [1:0]             pd;
    logic [3:0]             lf;
    logic [OFFSET_BITS-1:0] co;
    logic [19:0]            cr;
    logic [15:0]            cc;
    logic [OFFSET_BITS-1:0] so;
    logic [19:0]            sr;
    logic [15:0]            sc;
    logic [LENGTH_BITS-1:0] rl;
    logic [63:0]            acc;
    logic [23:0]            idp;
  } st_t;

  st_t state, s;
  ctlt_pkg::tok_t [2:0] tk;
  logic [1:0] n;
  logic do_flush, do_idle, hex;
  logic [5:0] k;
  ctlt_pkg::mode_t im;

  function automatic st_t consume(st_t a, logic [7:0] c);
    st_t r;
    r = a;
    r.rl = (a.rl == LEN_MAX) ? a.rl : a.rl + 1'b1;
    r.co = (a.co == OFF_MAX) ? a.co : a.co + 1'b1;
    if (c == ctlt_pkg::CH_NL) begin
      r.cr = (a.cr == ROW_MAX) ? a.cr : a.cr + 1'b1;
      r.cc = 16'd1;
    end else begin
      r.cc = (a.cc == COL_MAX) ? a.cc : a.cc + 1'b1;
    end
    return r;
  endfunction

  function automatic st_t start_tok(st_t a);
    st_t r;
    r = a;
    r.so = a.co;
    r.sr = a.cr;
    r.sc = a.cc;
    r.rl = '0;
    return r;
  endfunction

  function automatic ctlt_pkg::tok_t mk(st_t a, logic [5:0] kind, logic [1:0] err,
                                        logic [LENGTH_BITS-1:0] len, logic [63:0] v);
    ctlt_pkg::tok_t t;
    logic [63:0] o64;
    logic [31:0] l32;
    o64 = 64'(a.so);
    l32 = 32'(len);
    t.token_kind = kind;
    t.error_code = err;
    t.start_offset = o64[31:0];
    t.start_row = a.sr;
    t.start_column = a.sc;
    t.token_length = l32[15:0];
    t.int_value = v;
    t.last_of_run = 1'b0;
    return t;
  endfunction

  function automatic logic [63:0] acc_push(logic [63:0] a, logic [3:0] d, logic hx);
    logic [67:0] t;
    if (hx) begin
      t = {a, 4'b0000} | 68'(d);
    end else begin
      t = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + 68'(d);
    end
    return (t[67:64] != 4'd0) ? '1 : t[63:0];
  endfunction

  function automatic logic [5:0] ident_kind(st_t a);
    logic [5:0] r;
    r = ctlt_pkg::K_IDENT;
    if (a.rl == LENGTH_BITS'(3) && a.idp == ctlt_pkg::ID_AND) r = ctlt_pkg::K_AND;
    else if (a.rl == LENGTH_BITS'(3) && a.idp == ctlt_pkg::ID_NOT) r = ctlt_pkg::K_NOT;
    else if (a.rl == LENGTH_BITS'(2) && a.idp == ctlt_pkg::ID_OR) r = ctlt_pkg::K_OR;
    return r;
  endfunction

  always_comb begin
    s = state;
    tk = '0;
    n = 2'd0;
    do_flush = 1'b0;
    do_idle = 1'b0;
    hex = state.lf[0];
    k = ctlt_pkg::K_END;
    im = ctlt_pkg::M_IDLE;
    if (end_of_text) begin
      do_flush = 1'b1;
    end else begin
      case (state.m)
        ctlt_pkg::M_IDLE: do_idle = 1'b1;
        ctlt_pkg::M_DOT: begin
          if (char_byte == ".") begin
            s = consume(s, char_byte);
            if (s.pd < 2'd2) begin
              s.pd = 2'd2;
            end else begin
              tk[n] = mk(s, ctlt_pkg::K_ELLIPSIS, ctlt_pkg::E_NONE, s.rl, '0);
              n = n + 2'd1;
              s.m = ctlt_pkg::M_IDLE;
              s.pd = 2'd0;
            end
          end else if (ctlt_pkg::is_dec(char_byte)) begin
            if (s.pd >= 2'd2) begin
              tk[n] = mk(s, ctlt_pkg::K_DOT, ctlt_pkg::E_NONE, LENGTH_BITS'(1), '0);
              n = n + 2'd1;
              s.so = (s.so == OFF_MAX) ? s.so : s.so + 1'b1;
              s.sc = (s.sc == COL_MAX) ? s.sc : s.sc + 1'b1;
              s.rl = LENGTH_BITS'(1);
            end
            s = consume(s, char_byte);
            s.lf = 4'd2;
            s.acc = '0;
            s.pd = 2'd0;
            s.m = ctlt_pkg::M_FRAC;
          end else begin
            do_flush = 1'b1;
            do_idle = 1'b1;
          end
        end
        ctlt_pkg::M_LINECMT: begin
          if (char_byte == ctlt_pkg::CH_NL) begin
            s.m = ctlt_pkg::M_IDLE;
            do_idle = 1'b1;
          end else begin
            s = consume(s, char_byte);
          end
        end
        ctlt_pkg::M_BLOCK: begin
          s = consume(s, char_byte);
          if (char_byte == "*") s.m = ctlt_pkg::M_BLOCKSTAR;
        end
        ctlt_pkg::M_BLOCKSTAR: begin
          s = consume(s, char_byte);
          if (char_byte == "/") s.m = ctlt_pkg::M_IDLE;
          else if (char_byte != "*") s.m = ctlt_pkg::M_BLOCK;
        end
        ctlt_pkg::M_STRING: begin
          if (char_byte == "\"") begin
            s = consume(s, char_byte);
            tk[n] = mk(s, ctlt_pkg::K_STRING, ctlt_pkg::E_NONE, s.rl, '0);
            n = n + 2'd1;
            s.m = ctlt_pkg::M_IDLE;
          end else if (char_byte == ctlt_pkg::CH_NL) begin
            do_flush = 1'b1;
            do_idle = 1'b1;
          end else begin
            s = consume(s, char_byte);
          end
        end
        ctlt_pkg::M_IDENT: begin
          if (ctlt_pkg::is_word(char_byte)) begin
            if (s.rl < LENGTH_BITS'(3)) s.idp = {s.idp[15:0], char_byte};
            s = consume(s, char_byte);
          end else begin
            do_flush = 1'b1;
            do_idle = 1'b1;
          end
        end
        ctlt_pkg::M_ZERO, ctlt_pkg::M_INTDIG: begin
          if (state.m == ctlt_pkg::M_ZERO && char_byte == "x") begin
            s = consume(s, char_byte);
            s.lf[0] = 1'b1;
            s.acc = '0;
            s.m = ctlt_pkg::M_INTDIG;
          end else if (ctlt_pkg::is_digit(char_byte, hex)) begin
            s = consume(s, char_byte);
            s.acc = acc_push(s.acc, ctlt_pkg::digit_val(char_byte), hex);
            s.m = ctlt_pkg::M_INTDIG;
          end else if (char_byte == ".") begin
            s = consume(s, char_byte);
            s.lf[1] = 1'b1;
            s.m = ctlt_pkg::M_FRAC;
          end else if (ctlt_pkg::is_exp(char_byte, hex)) begin
            s = consume(s, char_byte);
            s.lf[1] = 1'b1;
            s.m = ctlt_pkg::M_EXP;
          end else begin
            do_flush = 1'b1;
            do_idle = 1'b1;
          end
        end
        ctlt_pkg::M_FRAC: begin
          if (ctlt_pkg::is_digit(char_byte, hex)) begin
            s = consume(s, char_byte);
          end else if (ctlt_pkg::is_exp(char_byte, hex)) begin
            s = consume(s, char_byte);
            s.m = ctlt_pkg::M_EXP;
          end else begin
            do_flush = 1'b1;
            do_idle = 1'b1;
          end
        end
        ctlt_pkg::M_EXP: begin
          if (char_byte == "+" || char_byte == "-" || ctlt_pkg::is_dec(char_byte)) begin
            s = consume(s, char_byte);
            s.m = ctlt_pkg::M_EXPDIG;
          end else begin
            do_flush = 1'b1;
            do_idle = 1'b1;
          end
        end
        ctlt_pkg::M_EXPDIG: begin
          if (ctlt_pkg::is_dec(char_byte)) begin
            s = consume(s, char_byte);
          end else begin
            do_flush = 1'b1;
            do_idle = 1'b1;
          end
        end
        default: begin
          im = ctlt_pkg::op_chain(state.m, char_byte);
          k = ctlt_pkg::op_ext(state.m, char_byte);
          if (im != ctlt_pkg::M_IDLE) begin
            s = consume(s, char_byte);
            s.m = im;
          end else if (k != ctlt_pkg::K_END) begin
            s = consume(s, char_byte);
            tk[n] = mk(s, k, ctlt_pkg::E_NONE, s.rl, '0);
            n = n + 2'd1;
            s.m = ctlt_pkg::M_IDLE;
          end else begin
            do_flush = 1'b1;
            do_idle = 1'b1;
          end
        end
      endcase
    end

    if (do_flush) begin
      case (s.m)
        ctlt_pkg::M_IDLE, ctlt_pkg::M_LINECMT: begin
        end
        ctlt_pkg::M_DOT: begin
          tk[n] = mk(s, ctlt_pkg::K_DOT, ctlt_pkg::E_NONE, LENGTH_BITS'(1), '0);
          n = n + 2'd1;
          if (s.pd >= 2'd2) begin
            s.so = (s.so == OFF_MAX) ? s.so : s.so + 1'b1;
            s.sc = (s.sc == COL_MAX) ? s.sc : s.sc + 1'b1;
            tk[n] = mk(s, ctlt_pkg::K_DOT, ctlt_pkg::E_NONE, LENGTH_BITS'(1), '0);
            n = n + 2'd1;
          end
        end
        ctlt_pkg::M_BLOCK, ctlt_pkg::M_BLOCKSTAR: begin
          tk[n] = mk(s, ctlt_pkg::K_ERROR, ctlt_pkg::E_BLOCK, s.rl, '0);
          n = n + 2'd1;
        end
        ctlt_pkg::M_STRING: begin
          tk[n] = mk(s, ctlt_pkg::K_ERROR, ctlt_pkg::E_STRING, s.rl, '0);
          n = n + 2'd1;
        end
        ctlt_pkg::M_IDENT: begin
          tk[n] = mk(s, ident_kind(s), ctlt_pkg::E_NONE, s.rl, '0);
          n = n + 2'd1;
        end
        ctlt_pkg::M_ZERO, ctlt_pkg::M_INTDIG, ctlt_pkg::M_FRAC, ctlt_pkg::M_EXP,
        ctlt_pkg::M_EXPDIG: begin
          if (s.lf[1]) begin
            tk[n] = mk(s, ctlt_pkg::K_FLOAT, ctlt_pkg::E_NONE, s.rl, '0);
          end else begin
            tk[n] = mk(s, ctlt_pkg::K_INT, ctlt_pkg::E_NONE, s.rl, s.acc);
          end
          n = n + 2'd1;
        end
        default: begin
          if (ctlt_pkg::op_default(s.m) != ctlt_pkg::K_END) begin
            tk[n] = mk(s, ctlt_pkg::op_default(s.m), ctlt_pkg::E_NONE, s.rl, '0);
            n = n + 2'd1;
          end
        end
      endcase
      s.m = ctlt_pkg::M_IDLE;
      s.pd = 2'd0;
    end

    if (end_of_text) begin
      s = start_tok(s);
      tk[n] = mk(s, ctlt_pkg::K_END, ctlt_pkg::E_NONE, '0, '0);
      n = n + 2'd1;
    end

    if (do_idle) begin
      s = start_tok(s);
      if (ctlt_pkg::is_blank(char_byte)) begin
        s = consume(s, char_byte);
      end else begin
        k = ctlt_pkg::idle_kind(char_byte);
        im = ctlt_pkg::idle_mode(char_byte);
        s = consume(s, char_byte);
        if (k != ctlt_pkg::K_END) begin
          tk[n] = mk(s, k, ctlt_pkg::E_NONE, s.rl, '0);
          n = n + 2'd1;
        end else if (im != ctlt_pkg::M_IDLE) begin
          s.m = im;
          s.pd = (im == ctlt_pkg::M_DOT) ? 2'd1 : 2'd0;
        end else if (ctlt_pkg::is_dec(char_byte)) begin
          s.lf = 4'd0;
          s.acc = {60'd0, char_byte[3:0]};
          s.m = (char_byte == "0") ? ctlt_pkg::M_ZERO : ctlt_pkg::M_INTDIG;
        end else if (ctlt_pkg::is_alpha(char_byte) || char_byte == "_") begin
          s.idp = {16'd0, char_byte};
          s.m = ctlt_pkg::M_IDENT;
        end else begin
          tk[n] = mk(s, ctlt_pkg::K_ERROR, ctlt_pkg::E_BYTE, s.rl, '0);
          n = n + 2'd1;
        end
      end
    end

    for (int i = 0; i < 3; i++) begin
      tk[i].last_of_run = (2'(i) == n - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.m <= ctlt_pkg::M_IDLE;
      state.pd <= 2'd0;
      state.lf <= 4'd0;
      state.co <= '0;
      state.cr <= 20'd1;
      state.cc <= 16'd1;
      state.so <= '0;
      state.sr <= 20'd1;
      state.sc <= 16'd1;
      state.rl <= '0;
      state.acc <= '0;
      state.idp <= '0;
    end else if (take) begin
      state <= s;
    end
  end

  assign toks = tk;
  assign tok_cnt = n;

endmodule

[rtl/core/ctlt_tokq.sv]
// Four-entry token queue that takes up to three tokens per transaction and
// delivers one per cycle while the output is ready. Depends on ctlt_pkg and ctlt_ifs.
module ctlt_tokq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ctlt_pkg::tok_t [2:0] toks,
  input  logic [1:0]           tok_cnt,
  output logic                 room,
  ctlt_out_if.source           out_ch
);

  ctlt_pkg::tok_t q [4];
  logic [1:0] wp, rp;
  logic [2:0] count;
  logic [1:0] push_cnt;
  logic pop;
  ctlt_pkg::tok_t head;

  assign push_cnt = push ? tok_cnt : 2'd0;
  assign pop = out_ch.valid && out_ch.ready;
  assign room = count <= 3'd1;
  assign head = q[rp];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_cnt) q[wp + 2'(i)] <= toks[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 2'd0;
      rp <= 2'd0;
      count <= 3'd0;
    end else begin
      wp <= wp + push_cnt;
      rp <= rp + {1'b0, pop};
      count <= count + {1'b0, push_cnt} - {2'b00, pop};
    end
  end

  assign out_ch.valid = count != 3'd0;
  assign out_ch.token_kind = head.token_kind;
  assign out_ch.error_code = head.error_code;
  assign out_ch.start_offset = head.start_offset;
  assign out_ch.start_row = head.start_row;
  assign out_ch.start_column = head.start_column;
  assign out_ch.token_length = head.token_length;
  assign out_ch.int_value = head.int_value;
  assign out_ch.last_of_run = head.last_of_run;

endmodule

[rtl/core/ctlt_checker.sv]
// Port-level checks on the tokenizer output channel, bound to the top level.
// Depends on ctlt_pkg.
module ctlt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  token_kind,
  input logic [1:0]  error_code,
  input logic [15:0] token_length,
  input logic [63:0] int_value,
  input logic        last_of_run
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(int_value))
    else $error("Stalled output transaction changed.");

  a_end_tok: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == ctlt_pkg::K_END |-> last_of_run && token_length == 16'd0)
    else $error("End token not last or not empty.");

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ctlt_pkg::E_NONE |-> token_kind == ctlt_pkg::K_ERROR)
    else $error("Error code on a non-error token.");

  a_val_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && int_value != 64'd0 |-> token_kind == ctlt_pkg::K_INT)
    else $error("Integer value on a non-integer token.");

endmodule

bind c_like_byte_stream_tokenizer_top ctlt_checker u_ctlt_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .token_kind(out_ch.token_kind),
  .error_code(out_ch.error_code),
  .token_length(out_ch.token_length),
  .int_value(out_ch.int_value),
  .last_of_run(out_ch.last_of_run)
);
